### rtl/core/integer_to_roman_encoder_core_defines.svh
// ----------------------------------------------------------------------------
// Integer to Roman encoder core: assertion macros
// Shared concurrent assertion forms, sampled on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ROMAN_ENCODER_CORE_DEFINES_SVH
`define INTEGER_TO_ROMAN_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication: the condition must hold whenever the trigger holds.
`define IRENC_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("irenc assertion failed");

// Next-cycle implication: the condition must hold in the cycle after the trigger.
`define IRENC_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("irenc assertion failed");

`endif

### rtl/core/irenc_pkg.sv
// ----------------------------------------------------------------------------
// Integer to Roman encoder package
// Types, letter codes and the greedy step tables shared by the core modules.
// ----------------------------------------------------------------------------
package irenc_pkg;

    localparam int VALUE_W    = 12;
    localparam int SYMBOL_W   = 8;
    localparam int STEP_COUNT = 13;
    localparam int STEP_W     = 4;

    localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

    // ASCII codes of the numeral letters.
    localparam logic [SYMBOL_W-1:0] SYM_NONE = 8'h00;
    localparam logic [SYMBOL_W-1:0] SYM_I    = 8'h49;
    localparam logic [SYMBOL_W-1:0] SYM_V    = 8'h56;
    localparam logic [SYMBOL_W-1:0] SYM_X    = 8'h58;
    localparam logic [SYMBOL_W-1:0] SYM_L    = 8'h4C;
    localparam logic [SYMBOL_W-1:0] SYM_C    = 8'h43;
    localparam logic [SYMBOL_W-1:0] SYM_D    = 8'h44;
    localparam logic [SYMBOL_W-1:0] SYM_M    = 8'h4D;

    // One queued word: the value and its out-of-range flag.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               err;
    } t_item;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    // Weight of each greedy step, largest first.
    function automatic logic [VALUE_W-1:0] step_value(input logic [STEP_W-1:0] idx);
        case (idx)
            4'd0:    return 12'd1000;
            4'd1:    return 12'd900;
            4'd2:    return 12'd500;
            4'd3:    return 12'd400;
            4'd4:    return 12'd100;
            4'd5:    return 12'd90;
            4'd6:    return 12'd50;
            4'd7:    return 12'd40;
            4'd8:    return 12'd10;
            4'd9:    return 12'd9;
            4'd10:   return 12'd5;
            4'd11:   return 12'd4;
            default: return 12'd1;
        endcase
    endfunction

    // First letter of each step.
    function automatic logic [SYMBOL_W-1:0] step_first(input logic [STEP_W-1:0] idx);
        case (idx)
            4'd0:    return SYM_M;
            4'd1:    return SYM_C;
            4'd2:    return SYM_D;
            4'd3:    return SYM_C;
            4'd4:    return SYM_C;
            4'd5:    return SYM_X;
            4'd6:    return SYM_L;
            4'd7:    return SYM_X;
            4'd8:    return SYM_X;
            4'd9:    return SYM_I;
            4'd10:   return SYM_V;
            4'd11:   return SYM_I;
            default: return SYM_I;
        endcase
    endfunction

    // Second letter of each step; SYM_NONE for single-letter steps.
    function automatic logic [SYMBOL_W-1:0] step_second(input logic [STEP_W-1:0] idx);
        case (idx)
            4'd1:    return SYM_M;
            4'd3:    return SYM_D;
            4'd5:    return SYM_C;
            4'd7:    return SYM_L;
            4'd9:    return SYM_X;
            4'd11:   return SYM_V;
            default: return SYM_NONE;
        endcase
    endfunction

endpackage

### rtl/core/irenc_front.sv
// ----------------------------------------------------------------------------
// Integer to Roman encoder front end
// Takes input words, flags out-of-range values and pushes them to the queue.
// ----------------------------------------------------------------------------
module irenc_front
    import irenc_pkg::*;
(
    input  logic               start,
    input  logic [VALUE_W-1:0] i_value,
    input  t_queue_stat        i_stat,
    output logic               busy,
    output logic               o_push,
    output t_item              o_item
);

    // The front stalls only when the queue has no room.
    assign busy   = i_stat.full;
    assign o_push = start && !i_stat.full;

    // Zero and values past the largest numeral are flagged for one error word.
    assign o_item.value = i_value;
    assign o_item.err   = (i_value == '0) || (i_value > MAX_VALUE);

endmodule

### rtl/core/irenc_queue.sv
// ----------------------------------------------------------------------------
// Integer to Roman encoder queue
// Small register FIFO between the front end and the letter engine.
// ----------------------------------------------------------------------------
module irenc_queue
    import irenc_pkg::*;
#(
    parameter int P_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_item       i_item,
    input  logic        i_pop,
    output t_item       o_item,
    output t_queue_stat o_stat
);

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(P_DEPTH);

    t_item            r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_item       = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### rtl/core/irenc_back.sv
// ----------------------------------------------------------------------------
// Integer to Roman encoder letter engine
// Pops queued words and, while a word is in progress, emits one numeral letter per cycle by greedy steps.
// ----------------------------------------------------------------------------
module irenc_back
    import irenc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_item               i_item,
    input  t_queue_stat         i_stat,
    output logic                o_pop,
    output logic                o_strobe,
    output logic [SYMBOL_W-1:0] o_symbol,
    output logic                o_last,
    output logic                o_error
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_PEND = 3'b100
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [VALUE_W-1:0]  r_rest;
    logic [VALUE_W-1:0]  n_rest;
    logic                r_err;
    logic                n_err;
    logic [SYMBOL_W-1:0] r_pend_sym;
    logic [SYMBOL_W-1:0] n_pend_sym;
    logic                r_strobe;
    logic [SYMBOL_W-1:0] r_symbol;
    logic                r_last;
    logic                r_error;

    logic [STEP_COUNT-1:0] hit;
    logic [STEP_W-1:0]     sel;
    logic [VALUE_W-1:0]    diff;
    logic                  emit;
    logic [SYMBOL_W-1:0]   sym;
    logic                  last;
    logic                  done;
    logic                  load;

    // Pick the largest step that still fits the remaining value.
    always_comb begin
        for (int i = 0; i < STEP_COUNT; i++) begin
            hit[i] = (r_rest >= step_value(STEP_W'(i)));
        end
        sel = STEP_W'(STEP_COUNT - 1);
        for (int i = STEP_COUNT - 1; i >= 0; i--) begin
            if (hit[i]) begin
                sel = STEP_W'(i);
            end
        end
    end

    assign diff = r_rest - step_value(sel);

    // Letter generation and sequencing.
    always_comb begin
        n_state    = r_state;
        n_rest     = r_rest;
        n_err      = r_err;
        n_pend_sym = r_pend_sym;
        emit       = 1'b0;
        sym        = SYM_NONE;
        last       = 1'b0;
        done       = 1'b0;
        case (r_state)
            S_RUN: begin
                emit = 1'b1;
                if (r_err) begin
                    last = 1'b1;
                    done = 1'b1;
                end else begin
                    sym    = step_first(sel);
                    n_rest = diff;
                    if (step_second(sel) != SYM_NONE) begin
                        n_pend_sym = step_second(sel);
                        n_state    = S_PEND;
                    end else begin
                        last = (diff == '0);
                        done = last;
                    end
                end
            end
            S_PEND: begin
                emit = 1'b1;
                sym  = r_pend_sym;
                last = (r_rest == '0);
                done = last;
                if (!last) begin
                    n_state = S_RUN;
                end
            end
            default: begin
            end
        endcase

        // Take the next word on the cycle the current one finishes.
        load = ((r_state == S_IDLE) || done) && !i_stat.empty;
        if (load) begin
            n_state = S_RUN;
            n_rest  = i_item.value;
            n_err   = i_item.err;
        end else if (done) begin
            n_state = S_IDLE;
        end
    end

    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= emit;
        end
    end

    // Data path registers need no reset.
    always_ff @(posedge i_clk) begin
        r_rest     <= n_rest;
        r_err      <= n_err;
        r_pend_sym <= n_pend_sym;
        r_symbol   <= sym;
        r_last     <= last;
        r_error    <= r_err && (r_state == S_RUN);
    end

    assign o_strobe = r_strobe;
    assign o_symbol = r_symbol;
    assign o_last   = r_last;
    assign o_error  = r_error;

endmodule

### rtl/core/integer_to_roman_encoder_core.sv
// ----------------------------------------------------------------------------
// Integer to Roman encoder core
// Path: with the engine idle, a taken word passes the queue, the engine state and the output registers.
// Throughput: one letter per cycle while a word is in progress, 1 to 15 per value (one for an error word);
// an idle engine first pops the word before its letters start; the receiver cannot stall.
// Reset: synchronous active-low reset empties the queue and idles the engine.
// ----------------------------------------------------------------------------
`include "integer_to_roman_encoder_core_defines.svh"

module integer_to_roman_encoder_core
    import irenc_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_strobe,
    output logic [SYMBOL_W-1:0] o_symbol,
    output logic                o_last,
    output logic                o_error
);

    t_queue_stat stat;
    t_item       push_item;
    t_item       pop_item;
    logic        push;
    logic        pop;
    logic        good_sym;

    // Front end: accept and classify.
    irenc_front u_front (
        .start   (start),
        .i_value (i_value),
        .i_stat  (stat),
        .busy    (busy),
        .o_push  (push),
        .o_item  (push_item)
    );

    // Queue between the two halves.
    irenc_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_stat  (stat)
    );

    // Back end: letter generation.
    irenc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (pop_item),
        .i_stat   (stat),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_symbol (o_symbol),
        .o_last   (o_last),
        .o_error  (o_error)
    );

    // Set when the output symbol is one of the seven numeral letters.
    assign good_sym = (o_symbol == SYM_I) || (o_symbol == SYM_V) || (o_symbol == SYM_X)
                   || (o_symbol == SYM_L) || (o_symbol == SYM_C) || (o_symbol == SYM_D)
                   || (o_symbol == SYM_M);

    // An error word is a single letterless word that closes its value.
    `IRENC_ASSERT_SAME(a_error_word, o_strobe && o_error, o_last && (o_symbol == SYM_NONE))

    // A good word always carries one of the seven numeral letters.
    `IRENC_ASSERT_SAME(a_letter_code, o_strobe && !o_error, good_sym)

    // A taken word lands in the queue.
    `IRENC_ASSERT_NEXT(a_push_lands, start && !busy, !stat.empty)

    // The engine never pops an empty queue.
    `IRENC_ASSERT_SAME(a_pop_nonempty, pop, !stat.empty)

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// Integer to Roman encoder core testbench
// Sends words through the start/busy handshake and checks every letter
// strobe against a digit-by-digit prediction of the numeral. The word set
// covers range edges, subtractive forms and random words with idle bursts.
// ----------------------------------------------------------------------------
module tb;
    import irenc_pkg::*;

    localparam int LATENCY     = 2;
    localparam int CYCLE_LIMIT = 200000;

    // One predicted letter strobe.
    typedef struct {
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
        logic                error;
    } t_letter;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [VALUE_W-1:0]  i_value;
    logic                o_strobe;
    logic [SYMBOL_W-1:0] o_symbol;
    logic                o_last;
    logic                o_error;

    t_letter             expected_letters[$];
    logic [SYMBOL_W-1:0] numeral_buf[$];
    int                  letter_errors;
    int                  cycle_count;
    bit                  idle_en;

    integer_to_roman_encoder_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_value  (i_value),
        .o_strobe (o_strobe),
        .o_symbol (o_symbol),
        .o_last   (o_last),
        .o_error  (o_error)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Cycle counter with a hard stop if the run hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL integer_to_roman_encoder_core");
            $finish;
        end
    end

    // Append the letters of one decimal digit, given its unit, five and ten.
    task automatic put_digit(input int d, input logic [SYMBOL_W-1:0] one,
                             input logic [SYMBOL_W-1:0] five,
                             input logic [SYMBOL_W-1:0] ten);
        if (d == 9) begin
            numeral_buf.push_back(one);
            numeral_buf.push_back(ten);
        end else if (d == 4) begin
            numeral_buf.push_back(one);
            numeral_buf.push_back(five);
        end else begin
            if (d >= 5)
                numeral_buf.push_back(five);
            repeat (d % 5) numeral_buf.push_back(one);
        end
    endtask

    // Predict the letter strobes of one accepted word.
    task automatic predict_numeral(input logic [VALUE_W-1:0] v);
        int      n;
        t_letter item;
        n = int'(v);
        numeral_buf.delete();
        if (n == 0 || n > int'(MAX_VALUE)) begin
            item.symbol = SYM_NONE;
            item.last   = 1'b1;
            item.error  = 1'b1;
            expected_letters.push_back(item);
        end else begin
            put_digit(n / 1000, SYM_M, SYM_NONE, SYM_NONE);
            put_digit((n / 100) % 10, SYM_C, SYM_D, SYM_M);
            put_digit((n / 10) % 10, SYM_X, SYM_L, SYM_C);
            put_digit(n % 10, SYM_I, SYM_V, SYM_X);
            foreach (numeral_buf[k]) begin
                item.symbol = numeral_buf[k];
                item.last   = (k == numeral_buf.size() - 1);
                item.error  = 1'b0;
                expected_letters.push_back(item);
            end
        end
    endtask

    // Send one word, with an optional idle burst first; start stays high after.
    task automatic send_word(input logic [VALUE_W-1:0] v);
        int gap;
        if (idle_en && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 9);
            start <= 1'b0;
            repeat (gap) begin
                i_value <= VALUE_W'($urandom);
                @(posedge i_clk);
            end
        end
        start   <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        predict_numeral(v);
    endtask

    // Drop start and wait until every predicted letter has come out.
    task automatic wait_for_drain;
        start <= 1'b0;
        while (expected_letters.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 1) @(posedge i_clk);
    endtask

    // Pick a random word, mostly in range, sometimes at or past the edges.
    function automatic logic [VALUE_W-1:0] random_word;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return VALUE_W'($urandom_range(4000, 4095));
            2:       return VALUE_W'($urandom_range(0, 4095));
            3:       return VALUE_W'($urandom_range(1, 20));
            default: return VALUE_W'($urandom_range(1, 3999));
        endcase
    endfunction

    // Compare each letter strobe with the oldest prediction.
    always @(posedge i_clk) begin : check_letters
        t_letter want;
        if (i_rst_n && o_strobe) begin
            if (expected_letters.size() == 0) begin
                $display("%0t: unexpected letter, expected none, got symbol %h last %b error %b",
                         $time, o_symbol, o_last, o_error);
                letter_errors++;
            end else begin
                want = expected_letters.pop_front();
                if (o_symbol !== want.symbol) begin
                    $display("%0t: symbol mismatch, expected %h, got %h",
                             $time, want.symbol, o_symbol);
                    letter_errors++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last mismatch, expected %b, got %b",
                             $time, want.last, o_last);
                    letter_errors++;
                end
                if (o_error !== want.error) begin
                    $display("%0t: error flag mismatch, expected %b, got %b",
                             $time, want.error, o_error);
                    letter_errors++;
                end
            end
        end
    end

    // Range edges, the longest numeral and the out-of-range words.
    task automatic test_range_edges;
        send_word(12'd1);
        send_word(12'd3999);
        send_word(12'd0);
        send_word(12'd4000);
        send_word(12'd4095);
        send_word(12'd3888);
        send_word(12'd2048);
        send_word(12'd2047);
        send_word(12'd2730);
        send_word(12'd1365);
    endtask

    // Every single letter but I, and every subtractive pair.
    task automatic test_subtractive_forms;
        send_word(12'd5);
        send_word(12'd10);
        send_word(12'd50);
        send_word(12'd100);
        send_word(12'd500);
        send_word(12'd1000);
        send_word(12'd4);
        send_word(12'd9);
        send_word(12'd40);
        send_word(12'd90);
        send_word(12'd400);
        send_word(12'd900);
        send_word(12'd1994);
        send_word(12'd3444);
    endtask

    // Random words with idle bursts.
    task automatic test_random_words(input int count);
        idle_en = 1'b1;
        repeat (count) send_word(random_word());
    endtask

    // Hold off until the engine is empty, then resume.
    task automatic test_drain_pause;
        wait_for_drain();
        send_word(12'd3888);
        send_word(12'd0);
        wait_for_drain();
    endtask

    // Back-to-back words with no idling.
    task automatic test_back_to_back(input int count);
        idle_en = 1'b0;
        repeat (count) send_word(random_word());
    endtask

    // Main sequence.
    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_value       = '0;
        idle_en       = 1'b0;
        letter_errors = 0;
        cycle_count   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_range_edges();
        test_subtractive_forms();
        test_random_words(60);
        test_drain_pause();
        test_random_words(50);
        test_back_to_back(45);

        // Let the last numeral finish, then report.
        wait_for_drain();
        repeat (LATENCY + 16) @(posedge i_clk);
        if (letter_errors == 0 && expected_letters.size() == 0) begin
            $display("PASS integer_to_roman_encoder_core");
        end else begin
            $display("FAIL integer_to_roman_encoder_core");
        end
        $finish;
    end

endmodule
